>>> sv/bounded_array_set_table_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded array set table
// Concurrent checks sampled on the rising clock edge, masked during reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ARRAY_SET_TABLE_DEFINES_SVH
`define BOUNDED_ARRAY_SET_TABLE_DEFINES_SVH

// Same-cycle implication.
`define BAST_ASSERT_COMB(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BAST_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/bast_pkg.sv
// ----------------------------------------------------------------------------
// bast_pkg
// Shared widths, command codes, types and defaults of the array set table.
// ----------------------------------------------------------------------------
package bast_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd4;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_FIND,
    OP_REMOVE,
    OP_READ,
    OP_WRITE,
    OP_NOP
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_FULL,
    ST_NOT_FOUND,
    ST_RANGE
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_RD_WAIT
  } state_t;

  typedef struct packed {
    op_t                  op;
    logic [INDEX_W-1:0]   index;
    logic [VALUE_W-1:0]   value;
  } item_t;

  typedef struct packed {
    logic                 full;
    logic                 empty;
    logic [QCNT_W-1:0]    level;
  } q_sts_t;

endpackage

>>> sv/bast_in_if.sv
// ----------------------------------------------------------------------------
// bast_in_if
// Command channel: valid/ready handshake with command, value and index.
// ----------------------------------------------------------------------------
interface bast_in_if;
  import bast_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [VALUE_W-1:0] value;
  logic [INDEX_W-1:0] index;

  modport source (output valid, cmd, value, index, input ready);
  modport sink   (input valid, cmd, value, index, output ready);
endinterface

>>> sv/bast_out_if.sv
// ----------------------------------------------------------------------------
// bast_out_if
// Result channel: valid/ready handshake with status and result fields.
// ----------------------------------------------------------------------------
interface bast_out_if;
  import bast_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  found_index;
  logic [VALUE_W-1:0]  read_value;
  logic [FILL_W-1:0]   fill_count;

  modport source (output valid, status, found_index, read_value, fill_count, input ready);
  modport sink   (input valid, status, found_index, read_value, fill_count, output ready);
endinterface

>>> sv/bast_front.sv
// ----------------------------------------------------------------------------
// bast_front
// Accepts command beats and classifies the raw command code into an operation.
// ----------------------------------------------------------------------------
module bast_front (
  bast_in_if.sink          in_ch,
  output logic             q_valid,
  input  logic             q_ready,
  output bast_pkg::item_t  q_item
);
  import bast_pkg::*;

  op_t op;

  always_comb begin
    unique case (in_ch.cmd)
      CMD_PUSH:   op = OP_PUSH;
      CMD_FIND:   op = OP_FIND;
      CMD_REMOVE: op = OP_REMOVE;
      CMD_READ:   op = OP_READ;
      CMD_WRITE:  op = OP_WRITE;
      default:    op = OP_NOP;
    endcase
  end

  assign q_valid      = in_ch.valid;
  assign in_ch.ready  = q_ready;
  assign q_item.op    = op;
  assign q_item.index = in_ch.index;
  assign q_item.value = in_ch.value;

endmodule

>>> sv/bast_queue.sv
// ----------------------------------------------------------------------------
// bast_queue
// Short FIFO of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module bast_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  bast_pkg::item_t  push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output bast_pkg::item_t  pop_item,
  output bast_pkg::q_sts_t sts
);
  import bast_pkg::*;

  item_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] level_r, level_nxt;
  logic              full, empty, push, pop;

  assign full       = (level_r == QCNT_W'(QUEUE_DEPTH));
  assign empty      = (level_r == '0);
  assign push_ready = !full;
  assign pop_valid  = !empty;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slot_r[rd_ptr_r];

  assign sts.full  = full;
  assign sts.empty = empty;
  assign sts.level = level_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   level_nxt = level_r + 1'b1;
      2'b01:   level_nxt = level_r - 1'b1;
      default: level_nxt = level_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> sv/bast_back.sv
// ----------------------------------------------------------------------------
// bast_back
// Executes commands against the entry memory and fill count, and holds the
// result beat in an output register.
// ----------------------------------------------------------------------------
module bast_back #(
  parameter int DEPTH      = bast_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bast_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  output logic                             q_ready,
  input  bast_pkg::item_t                  q_item,
  bast_out_if.source                       out_ch,
  output logic [$clog2(DEPTH + 1)-1:0]     count_o
);
  import bast_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int EW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  op_t                   op_r, op_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [CW-1:0]         scan_r, scan_nxt;
  logic                  pend_r, pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               status_r, status_nxt;
  logic [INDEX_W-1:0]    found_r, found_nxt;
  logic [VALUE_W-1:0]    rdval_r, rdval_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;

  logic [DATA_WIDTH-1:0] mem_r [DEPTH];
  logic [DATA_WIDTH-1:0] mem_q_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata;

  logic [EW-1:0]         v_ext, r_ext;
  logic [DATA_WIDTH-1:0] q_val;
  logic [IW-1:0]         idx_ext, cnt_ext;
  logic                  idx_ok, out_free, take, scan_hit, scan_more;
  logic [CW-1:0]         count_last;

  logic                  res_load;
  status_t               res_status;
  logic [INDEX_W-1:0]    res_found;
  logic [VALUE_W-1:0]    res_rd;

  assign v_ext      = EW'(q_item.value);
  assign q_val      = v_ext[DATA_WIDTH-1:0];
  assign r_ext      = EW'(mem_q_r);
  assign idx_ext    = IW'(q_item.index);
  assign cnt_ext    = IW'(count_r);
  assign idx_ok     = (idx_ext < cnt_ext);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign take       = (state_r == S_IDLE) && q_valid && out_free;
  assign scan_hit   = pend_r && (mem_q_r == key_r);
  assign scan_more  = (scan_r < count_r);
  assign count_last = count_r - 1'b1;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          priority if (q_item.op == OP_FIND || q_item.op == OP_REMOVE) begin
            state_nxt = S_SCAN;
          end else if (q_item.op == OP_READ && idx_ok) begin
            state_nxt = S_RD_WAIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        priority if (scan_hit) begin
          state_nxt = (op_r == OP_REMOVE) ? S_MOVE : S_IDLE;
        end else if (scan_more) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MOVE:    state_nxt = S_IDLE;
      S_RD_WAIT: state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    count_nxt     = count_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    scan_nxt      = scan_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    found_nxt     = found_r;
    rdval_nxt     = rdval_r;
    fill_nxt      = fill_r;
    q_ready       = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = count_r[AW-1:0];
    mem_wdata     = q_val;
    mem_raddr     = scan_r[AW-1:0];
    res_load      = 1'b0;
    res_status    = ST_OK;
    res_found     = '0;
    res_rd        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          q_ready  = 1'b1;
          op_nxt   = q_item.op;
          key_nxt  = q_val;
          scan_nxt = '0;
          pend_nxt = 1'b0;
          unique case (q_item.op)
            OP_PUSH: begin
              res_load = 1'b1;
              if (count_r == CW'(DEPTH)) begin
                res_status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_r[AW-1:0];
                count_nxt = count_r + 1'b1;
              end
            end
            OP_FIND, OP_REMOVE: ;
            OP_READ: begin
              if (idx_ok) begin
                mem_raddr = idx_ext[AW-1:0];
              end else begin
                res_load   = 1'b1;
                res_status = ST_RANGE;
              end
            end
            OP_WRITE: begin
              res_load = 1'b1;
              if (idx_ok) begin
                mem_we    = 1'b1;
                mem_waddr = idx_ext[AW-1:0];
              end else begin
                res_status = ST_RANGE;
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        priority if (scan_hit) begin
          if (op_r == OP_REMOVE) begin
            // fetch the last entry to move into the matched slot
            mem_raddr = count_last[AW-1:0];
          end else begin
            res_load  = 1'b1;
            res_found = INDEX_W'(pos_r);
          end
        end else if (scan_more) begin
          // issue the next read while the previous one is compared
          mem_raddr = scan_r[AW-1:0];
          pos_nxt   = scan_r[AW-1:0];
          pend_nxt  = 1'b1;
          scan_nxt  = scan_r + 1'b1;
        end else begin
          res_load   = 1'b1;
          res_status = ST_NOT_FOUND;
        end
      end
      S_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = mem_q_r;
        count_nxt = count_r - 1'b1;
        res_load  = 1'b1;
      end
      S_RD_WAIT: begin
        res_load = 1'b1;
        res_rd   = r_ext[VALUE_W-1:0];
      end
      default: ;
    endcase

    if (res_load) begin
      out_valid_nxt = 1'b1;
      status_nxt    = res_status;
      found_nxt     = res_found;
      rdval_nxt     = res_rd;
      fill_nxt      = FILL_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    pos_r    <= pos_nxt;
    scan_r   <= scan_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    rdval_r  <= rdval_nxt;
    fill_r   <= fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= mem_r[mem_raddr];
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.found_index = found_r;
  assign out_ch.read_value  = rdval_r;
  assign out_ch.fill_count  = fill_r;
  assign count_o            = count_r;

endmodule

>>> sv/bounded_array_set_table.sv
// ----------------------------------------------------------------------------
// bounded_array_set_table: fixed-capacity value list with swap remove
// Commands pass the queue to the back end. Push, write, out-of-range and unknown
// commands answer from idle; read adds a memory read wait; find scans up to the
// fill count; remove adds a move of the last entry. The scan reads one entry a
// cycle from the single read port. Beats queue until the back end is idle with
// a free result. Reset clears the fill count, queue and result valid, not memory.
// ----------------------------------------------------------------------------
`include "bounded_array_set_table_defines.svh"

module bounded_array_set_table #(
  parameter int DEPTH      = bast_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bast_pkg::DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bast_in_if.sink    in_ch,
  bast_out_if.source out_ch
);
  import bast_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic          f_valid, f_ready;
  item_t         f_item;
  logic          b_valid, b_ready;
  item_t         b_item;
  q_sts_t        q_sts;
  logic [CW-1:0] count;

  bast_front u_front (
    .in_ch   (in_ch),
    .q_valid (f_valid),
    .q_ready (f_ready),
    .q_item  (f_item)
  );

  bast_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item),
    .sts        (q_sts)
  );

  bast_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (b_valid),
    .q_ready (b_ready),
    .q_item  (b_item),
    .out_ch  (out_ch),
    .count_o (count)
  );

  `BAST_ASSERT_COMB(a_count_bound, clk, rst_n, 1'b1, count <= CW'(DEPTH), "fill count above depth")
  `BAST_ASSERT_COMB(a_fill_match, clk, rst_n, out_ch.valid, out_ch.fill_count == FILL_W'(count), "result fill count differs from table count")
  `BAST_ASSERT_COMB(a_fields_ok, clk, rst_n, out_ch.valid && (out_ch.found_index != '0 || out_ch.read_value != '0), out_ch.status == ST_OK, "nonzero result field on failed command")
  `BAST_ASSERT_NEXT(a_queue_hold, clk, rst_n, f_valid && f_ready && !(b_valid && b_ready), !q_sts.empty, "queued beat lost")

endmodule

>>> tb/bounded_array_set_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_set_table_tb
// Drives push, find, remove, read, write and unknown commands into the table,
// keeps a shadow copy of the entries and fill count to predict every result,
// and checks each result beat field by field under random stalls on both ends.
// ----------------------------------------------------------------------------
module bounded_array_set_table_tb;
  import bast_pkg::*;

  localparam int TBL_DEPTH      = DEPTH_DEF;
  localparam int N_RANDOM       = 1400;
  localparam int QUIET_TAIL     = 150;
  localparam int MAX_ERR_PRINTS = 10;
  localparam int STALL_AT       = 600;
  localparam int STALL_CYCLES   = 160;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
  } table_cmd_t;

  typedef struct {
    status_t             status;
    logic [INDEX_W-1:0]  found_index;
    logic [VALUE_W-1:0]  read_value;
    logic [FILL_W-1:0]   fill_count;
  } table_result_t;

  logic clk;
  logic rst_n;

  bast_in_if  in_ch ();
  bast_out_if out_ch ();

  bounded_array_set_table #(
    .DEPTH      (TBL_DEPTH),
    .DATA_WIDTH (DATA_WIDTH_DEF)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  table_cmd_t         cmd_queue[$];
  table_result_t      result_queue[$];
  logic [VALUE_W-1:0] shadow_entries [TBL_DEPTH];
  int                 shadow_fill;
  int                 peak_fill;

  int n_total;
  int n_accepted;
  int n_results;
  int n_mismatch;
  int in_gap;
  int out_gap;
  bit in_taken;
  logic stall_hold;
  int cmd_seen [8];
  int status_seen [4];

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Idle in bursts, but leave every third stretch of 100 beats and the tail clean.
  function automatic bit idling_on();
    return ((n_accepted / 100) % 3 != 2) && (n_accepted < n_total - QUIET_TAIL);
  endfunction

  // Apply one command to the shadow table and return the result it should give.
  function automatic table_result_t table_apply(table_cmd_t c);
    table_result_t r;
    int pos;
    r.status      = ST_OK;
    r.found_index = '0;
    r.read_value  = '0;
    pos = -1;
    if (c.cmd == CMD_FIND || c.cmd == CMD_REMOVE) begin
      for (int k = 0; k < shadow_fill; k++) begin
        if (pos < 0 && shadow_entries[k] == c.value) pos = k;
      end
    end
    case (c.cmd)
      CMD_PUSH: begin
        if (shadow_fill >= TBL_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_entries[shadow_fill] = c.value;
          shadow_fill++;
        end
      end
      CMD_FIND: begin
        if (pos < 0) r.status = ST_NOT_FOUND;
        else r.found_index = INDEX_W'(pos);
      end
      CMD_REMOVE: begin
        if (pos < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          // swap the last entry into the hole
          shadow_fill--;
          shadow_entries[pos] = shadow_entries[shadow_fill];
        end
      end
      CMD_READ: begin
        if (int'(c.index) < shadow_fill) r.read_value = shadow_entries[c.index];
        else r.status = ST_RANGE;
      end
      CMD_WRITE: begin
        if (int'(c.index) < shadow_fill) shadow_entries[c.index] = c.value;
        else r.status = ST_RANGE;
      end
      default: ;
    endcase
    r.fill_count = FILL_W'(shadow_fill);
    return r;
  endfunction

  task automatic add_cmd(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value,
                         logic [INDEX_W-1:0] index);
    table_cmd_t c;
    c.cmd   = cmd;
    c.value = value;
    c.index = index;
    cmd_queue = {cmd_queue, c};
  endtask

  // Random part: phases that fill, drain or mix the table, with a small value
  // pool so that find and remove hit, duplicates included.
  task automatic build_random();
    logic [VALUE_W-1:0] pool [6];
    int stop_at;
    int phase_len;
    int w_push, w_find, w_remove, w_read, w_write;
    int roll;
    logic [VALUE_W-1:0] v;
    logic [INDEX_W-1:0] idx;
    stop_at = cmd_queue.size() + N_RANDOM;
    while (cmd_queue.size() < stop_at) begin
      case ($urandom_range(0, 2))
        0: begin w_push = 55; w_find = 70; w_remove = 78; w_read = 88; w_write = 97; end
        1: begin w_push = 15; w_find = 35; w_remove = 75; w_read = 87; w_write = 97; end
        default: begin
          w_push = 30; w_find = 50; w_remove = 68; w_read = 82; w_write = 96;
        end
      endcase
      for (int i = 0; i < 6; i++) begin
        if ($urandom_range(0, 7) == 0) pool[i] = $urandom_range(0, 1) ? '1 : '0;
        else pool[i] = $urandom();
      end
      phase_len = $urandom_range(20, 60);
      for (int j = 0; j < phase_len && cmd_queue.size() < stop_at; j++) begin
        roll = $urandom_range(0, 99);
        v    = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, 5)] : $urandom();
        idx  = $urandom_range(0, 1) ? INDEX_W'($urandom_range(0, 7))
                                    : INDEX_W'($urandom_range(0, 15));
        if (roll < w_push)        add_cmd(CMD_PUSH, v, idx);
        else if (roll < w_find)   add_cmd(CMD_FIND, v, idx);
        else if (roll < w_remove) add_cmd(CMD_REMOVE, v, idx);
        else if (roll < w_read)   add_cmd(CMD_READ, v, idx);
        else if (roll < w_write)  add_cmd(CMD_WRITE, $urandom(), idx);
        else add_cmd(CMD_WRITE + CMD_W'($urandom_range(1, 3)), $urandom(), idx);
      end
    end
  endtask

  // Accept side: predict on every command beat.
  always @(posedge clk) begin : cmd_accept
    table_cmd_t c;
    in_taken = 1'b0;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      c.cmd   = in_ch.cmd;
      c.value = in_ch.value;
      c.index = in_ch.index;
      result_queue = {result_queue, table_apply(c)};
      cmd_seen[c.cmd]++;
      if (shadow_fill > peak_fill) peak_fill = shadow_fill;
      n_accepted++;
      in_taken = 1'b1;
      if (idling_on() && $urandom_range(0, 4) == 0) in_gap = $urandom_range(1, 8);
    end
  end

  // Command driver: hold the beat until taken, then idle or advance.
  always @(negedge clk) begin : cmd_drive
    table_cmd_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        nxt = cmd_queue.pop_front();
        in_ch.cmd   <= nxt.cmd;
        in_ch.value <= nxt.value;
        in_ch.index <= nxt.index;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result ready: random bursts of backpressure plus one long hold-off.
  always @(negedge clk) begin : result_ready
    logic rdy;
    rdy = 1'b1;
    if (stall_hold) begin
      rdy = 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      rdy = 1'b0;
    end else if (idling_on() && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(0, 7);
      rdy = 1'b0;
    end
    out_ch.ready <= rdy;
  end

  initial begin
    stall_hold = 1'b0;
    wait (n_accepted >= STALL_AT);
    @(negedge clk);
    stall_hold <= 1'b1;
    repeat (STALL_CYCLES) @(negedge clk);
    stall_hold <= 1'b0;
  end

  always @(posedge clk) begin : result_check
    table_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      status_seen[out_ch.status]++;
      if (result_queue.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_ERR_PRINTS)
          $display("tb: unexpected result beat %0d: status %0d fill %0d",
                   n_results, out_ch.status, out_ch.fill_count);
      end else begin
        want = result_queue.pop_front();
        if (out_ch.status !== want.status || out_ch.found_index !== want.found_index ||
            out_ch.read_value !== want.read_value ||
            out_ch.fill_count !== want.fill_count) begin
          n_mismatch++;
          if (n_mismatch <= MAX_ERR_PRINTS)
            $display("tb: result %0d expected st %0d idx %0d data %h fill %0d, got st %0d idx %0d data %h fill %0d",
                     n_results, want.status, want.found_index, want.read_value,
                     want.fill_count, out_ch.status, out_ch.found_index,
                     out_ch.read_value, out_ch.fill_count);
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = CMD_PUSH;
    in_ch.value  = '0;
    in_ch.index  = '0;
    out_ch.ready = 1'b0;
    shadow_fill  = 0;
    peak_fill    = 0;
    n_accepted   = 0;
    n_results    = 0;
    n_mismatch   = 0;
    in_gap       = 0;
    out_gap      = 0;
    in_taken     = 1'b0;
    foreach (shadow_entries[i]) shadow_entries[i] = '0;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // directed: extremes, misses, range edges, remove of the only entry, unknowns
    add_cmd(CMD_PUSH,   32'hFFFF_FFFF, 4'd0);
    add_cmd(CMD_PUSH,   32'h0000_0000, 4'd15);
    add_cmd(CMD_FIND,   32'h0000_0000, 4'd0);
    add_cmd(CMD_FIND,   32'hFFFF_FFFF, 4'd0);
    add_cmd(CMD_FIND,   32'h0000_0005, 4'd0);
    add_cmd(CMD_READ,   32'h0,         4'd1);
    add_cmd(CMD_READ,   32'h0,         4'd2);
    add_cmd(CMD_READ,   32'h0,         4'd15);
    add_cmd(CMD_WRITE,  32'hA5A5_A5A5, 4'd0);
    add_cmd(CMD_WRITE,  32'h5A5A_5A5A, 4'd2);
    add_cmd(CMD_REMOVE, 32'h0000_0000, 4'd0);
    add_cmd(CMD_REMOVE, 32'h1234_5678, 4'd0);
    add_cmd(CMD_READ,   32'h0,         4'd0);
    add_cmd(CMD_REMOVE, 32'hA5A5_A5A5, 4'd0);
    add_cmd(CMD_FIND,   32'hA5A5_A5A5, 4'd0);
    add_cmd(CMD_READ,   32'h0,         4'd0);
    add_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 4'd0);
    add_cmd(CMD_WRITE + 3'd1, 32'hFFFF_FFFF, 4'd15);
    add_cmd(CMD_WRITE + 3'd2, 32'h0000_0000, 4'd0);
    add_cmd(CMD_WRITE + 3'd3, $urandom(), 4'($urandom_range(0, 15)));
    build_random();
    n_total = cmd_queue.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_total || result_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d commands (push %0d find %0d remove %0d read %0d write %0d other %0d)",
             n_accepted, cmd_seen[CMD_PUSH], cmd_seen[CMD_FIND], cmd_seen[CMD_REMOVE],
             cmd_seen[CMD_READ], cmd_seen[CMD_WRITE],
             cmd_seen[5] + cmd_seen[6] + cmd_seen[7]);
    $display("tb: %0d results, ok %0d full %0d miss %0d range %0d, peak fill %0d, %0d bad",
             n_results, status_seen[ST_OK], status_seen[ST_FULL],
             status_seen[ST_NOT_FOUND], status_seen[ST_RANGE], peak_fill, n_mismatch);
    if (n_mismatch == 0 && result_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/bast_pkg.sv
sv/bast_in_if.sv
sv/bast_out_if.sv
sv/bast_front.sv
sv/bast_queue.sv
sv/bast_back.sv
sv/bounded_array_set_table.sv
tb/bounded_array_set_table_tb.sv
